>>> sv/stc_pkg.sv
`default_nettype none

package stc_pkg;

  // Character codes
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;

  // Column field in a command word is sized for the widest supported line
  localparam int MAX_COL_W = 5;

  // Command queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // What the back end has to do for one character
  typedef enum logic [1:0] {
    CMD_DRAW    = 2'd0,  // store and draw one cell on the bottom row
    CMD_FILL    = 2'd1,  // store the character, then scroll
    CMD_NEWLINE = 2'd2   // scroll only
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [MAX_COL_W-1:0]  col;
    logic [7:0]            glyph;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/stc_in_if.sv
`default_nettype none

interface stc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

>>> sv/stc_out_if.sv
`default_nettype none

interface stc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] screen_row;
  logic [3:0] screen_column;
  logic [7:0] glyph;
  logic       refresh_now;
  logic       last;

  modport source (output valid, output screen_row, output screen_column, output glyph,
                  output refresh_now, output last, input ready);
  modport sink   (input valid, input screen_row, input screen_column, input glyph,
                  input refresh_now, input last, output ready);
endinterface

`default_nettype wire

>>> sv/stc_front.sv
`default_nettype none

module stc_front #(
  parameter int LINE_CHARS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    char_code,
  input  wire logic          q_full,
  output logic               push,
  output stc_pkg::cmd_t      push_cmd
);

  localparam int CW = $clog2(LINE_CHARS);
  localparam logic [CW-1:0] COL_LAST = CW'(LINE_CHARS - 1);

  logic [CW-1:0] cursor_r;
  logic [CW-1:0] cursor_nxt;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Classify the character and advance the cursor
  always_comb begin
    push_cmd.col   = stc_pkg::MAX_COL_W'(cursor_r);
    push_cmd.glyph = char_code;
    if (char_code == stc_pkg::NEWLINE_CODE) begin
      push_cmd.kind = stc_pkg::CMD_NEWLINE;
      cursor_nxt    = '0;
    end else if (cursor_r == COL_LAST) begin
      push_cmd.kind = stc_pkg::CMD_FILL;
      cursor_nxt    = '0;
    end else begin
      push_cmd.kind = stc_pkg::CMD_DRAW;
      cursor_nxt    = cursor_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else if (push) begin
      cursor_r <= cursor_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/stc_queue.sv
`default_nettype none

module stc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire stc_pkg::cmd_t  push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                q_valid,
  output stc_pkg::cmd_t       pop_cmd
);

  stc_pkg::cmd_t                    slot_r [0:stc_pkg::QUEUE_DEPTH-1];
  logic [stc_pkg::QUEUE_PTR_W-1:0]  wr_ptr_r;
  logic [stc_pkg::QUEUE_PTR_W-1:0]  rd_ptr_r;
  logic [stc_pkg::QUEUE_CNT_W-1:0]  count_r;
  logic [stc_pkg::QUEUE_CNT_W-1:0]  count_nxt;

  assign full    = (count_r == stc_pkg::QUEUE_CNT_W'(stc_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && q_valid)) begin
      count_nxt = count_r + stc_pkg::QUEUE_CNT_W'(1);
    end else if (!push && pop && q_valid) begin
      count_nxt = count_r - stc_pkg::QUEUE_CNT_W'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + stc_pkg::QUEUE_PTR_W'(1);
      end
      if (pop && q_valid) begin
        rd_ptr_r <= rd_ptr_r + stc_pkg::QUEUE_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/stc_back.sv
`default_nettype none

module stc_back #(
  parameter int TEXT_ROWS  = 4,
  parameter int LINE_CHARS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire stc_pkg::cmd_t  q_cmd,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [1:0]          out_row,
  output logic [3:0]          out_col,
  output logic [7:0]          out_glyph,
  output logic                out_refresh,
  output logic                out_last
);

  localparam int STORE_LINES = TEXT_ROWS - 1;
  localparam int RW    = $clog2(TEXT_ROWS);
  localparam int CW    = $clog2(LINE_CHARS);
  localparam int LW    = (STORE_LINES > 1) ? $clog2(STORE_LINES) : 1;
  localparam int AW    = LW + CW;
  localparam int DEPTH = 1 << AW;

  localparam logic [RW-1:0] ROW_LAST  = RW'(TEXT_ROWS - 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(LINE_CHARS - 1);
  localparam logic [LW-1:0] LINE_LAST = LW'(STORE_LINES - 1);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SCROLL = 2'b10
  } state_t;

  state_t        state_r, state_nxt;

  // Read-issue stage of the scroll
  logic          a_active_r, a_active_nxt;
  logic [RW-1:0] a_row_r, a_row_nxt;
  logic [CW-1:0] a_col_r, a_col_nxt;

  // Read-data stage of the scroll
  logic          b_valid_r, b_valid_nxt;
  logic [RW-1:0] b_row_r, b_row_nxt;
  logic [CW-1:0] b_col_r, b_col_nxt;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_row_r, out_row_nxt;
  logic [3:0]    out_col_r, out_col_nxt;
  logic [7:0]    out_glyph_r, out_glyph_nxt;
  logic          out_last_r, out_last_nxt;

  // Line store
  logic [7:0]    mem [0:DEPTH-1];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]    rdata_r;
  logic          rvalid_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  logic          out_free;
  logic          b_bottom;
  logic          b_final;
  logic [7:0]    b_glyph;
  logic [RW-1:0] b_row_up;
  logic [CW-1:0] q_col;

  assign out_free = !out_valid_r || out_ready;
  assign q_col    = q_cmd.col[CW-1:0];
  assign pop      = (state_r == ST_IDLE) && q_valid &&
                    ((q_cmd.kind != stc_pkg::CMD_DRAW) || out_free);

  // Glyph of the cell in the read-data stage; bottom row is always blank
  assign b_bottom = (b_row_r == ROW_LAST);
  assign b_final  = b_bottom && (b_col_r == COL_LAST);
  assign b_glyph  = (b_bottom || !rvalid_r) ? stc_pkg::SPACE_CODE : rdata_r;
  assign b_row_up = b_row_r - RW'(1);

  // Store write: a typed character, or a line moving up during a scroll
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {LINE_LAST, q_col};
    wr_data = q_cmd.glyph;
    if (pop && (q_cmd.kind != stc_pkg::CMD_NEWLINE)) begin
      wr_en = 1'b1;
    end else if ((state_r == ST_SCROLL) && out_free && b_valid_r && (b_row_r != '0)) begin
      wr_en   = 1'b1;
      wr_addr = {b_row_up[LW-1:0], b_col_r};
      wr_data = b_glyph;
    end
  end

  assign rd_en   = (state_r == ST_SCROLL) && out_free && a_active_r;
  assign rd_addr = {a_row_r[LW-1:0], a_col_r};

  // Control
  always_comb begin
    state_nxt     = state_r;
    a_active_nxt  = a_active_r;
    a_row_nxt     = a_row_r;
    a_col_nxt     = a_col_r;
    b_valid_nxt   = b_valid_r;
    b_row_nxt     = b_row_r;
    b_col_nxt     = b_col_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_glyph_nxt = out_glyph_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          if (q_cmd.kind == stc_pkg::CMD_DRAW) begin
            out_valid_nxt = 1'b1;
            out_row_nxt   = 2'(ROW_LAST);
            out_col_nxt   = 4'(q_col);
            out_glyph_nxt = q_cmd.glyph;
            out_last_nxt  = 1'b1;
          end else begin
            state_nxt    = ST_SCROLL;
            a_active_nxt = 1'b1;
            a_row_nxt    = '0;
            a_col_nxt    = '0;
            b_valid_nxt  = 1'b0;
          end
        end
      end
      ST_SCROLL: begin
        if (out_free) begin
          if (b_valid_r) begin
            out_valid_nxt = 1'b1;
            out_row_nxt   = 2'(b_row_r);
            out_col_nxt   = 4'(b_col_r);
            out_glyph_nxt = b_glyph;
            out_last_nxt  = b_final;
            if (!a_active_r) begin
              state_nxt = ST_IDLE;
            end
          end
          b_valid_nxt = a_active_r;
          b_row_nxt   = a_row_r;
          b_col_nxt   = a_col_r;
          if (a_active_r) begin
            if (a_col_r == COL_LAST) begin
              a_col_nxt = '0;
              if (a_row_r == ROW_LAST) begin
                a_active_nxt = 1'b0;
              end else begin
                a_row_nxt = a_row_r + RW'(1);
              end
            end else begin
              a_col_nxt = a_col_r + CW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_active_r  <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_active_r  <= a_active_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    a_row_r     <= a_row_nxt;
    a_col_r     <= a_col_nxt;
    b_row_r     <= b_row_nxt;
    b_col_r     <= b_col_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_glyph_r <= out_glyph_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Per-entry valid bits: an unwritten entry reads as a space
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Line store memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r  <= mem[rd_addr];
      rvalid_r <= vld_r[rd_addr];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_glyph   = out_glyph_r;
  assign out_refresh = out_last_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire

>>> sv/scrolling_text_console.sv
// A plain character gives its cell write via the command queue and output register.
// A newline or line-filling character gives TEXT_ROWS*LINE_CHARS writes, one per cycle
// while the receiver is ready, via the read-issue, read-data and output registers; the
// back end is busy until the last, set by the single read port of the line store.
// Input side takes one word per cycle into a 2-deep command queue unless it is full.
// Reset (rst_n low, synchronous) clears cursor, queue and control; store reads as spaces.
`default_nettype none

module scrolling_text_console #(
  parameter int TEXT_ROWS  = 4,
  parameter int LINE_CHARS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  stc_in_if.sink     in_ch,
  stc_out_if.source  out_ch
);

  logic           q_full;
  logic           push;
  stc_pkg::cmd_t  push_cmd;
  logic           pop;
  logic           q_valid;
  stc_pkg::cmd_t  pop_cmd;

  // Front end: cursor tracking and classification
  stc_front #(
    .LINE_CHARS (LINE_CHARS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .char_code (in_ch.char_code),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Command queue
  stc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_cmd  (pop_cmd)
  );

  // Back end: line store and cell-write sequencer
  stc_back #(
    .TEXT_ROWS  (TEXT_ROWS),
    .LINE_CHARS (LINE_CHARS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_cmd       (pop_cmd),
    .pop         (pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_row     (out_ch.screen_row),
    .out_col     (out_ch.screen_column),
    .out_glyph   (out_ch.glyph),
    .out_refresh (out_ch.refresh_now),
    .out_last    (out_ch.last)
  );

endmodule

`default_nettype wire

>>> tb/scrolling_text_console_tb.sv
`timescale 1ns / 1ps

module scrolling_text_console_tb;

  localparam int ROWS         = 4;
  localparam int COLS         = 16;
  localparam int STORE_CELLS  = (ROWS - 1) * COLS;
  localparam int DIR_N        = 23;
  localparam int RANDOM_CHARS = 188;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 60;

  typedef struct packed {
    logic [1:0] row;
    logic [3:0] col;
    logic [7:0] glyph;
    logic       refresh;
    logic       last;
  } cell_write_t;

  // one line of the directed table; typed rows carry their expected column
  typedef struct packed {
    logic [7:0] code;
    logic       typed;
    logic [3:0] col;
  } stim_row_t;

  logic clk;
  logic rst_n;

  stc_in_if  in_ch();
  stc_out_if out_ch();

  scrolling_text_console #(
    .TEXT_ROWS (ROWS),
    .LINE_CHARS(COLS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow copy of the console state
  logic [7:0]  shadow_lines [STORE_CELLS];
  int          shadow_cursor;
  cell_write_t pending_writes [$];

  int mismatches     = 0;
  int chars_sent     = 0;
  int scrolls_seen   = 0;
  int writes_checked = 0;
  int stall_cycles   = 0;
  int burst_left     = 0;
  bit hold_req       = 1'b0;

  function automatic cell_write_t make_write(input logic [1:0] row, input logic [3:0] col,
                                             input logic [7:0] glyph, input logic refresh,
                                             input logic last);
    cell_write_t w;
    w.row     = row;
    w.col     = col;
    w.glyph   = glyph;
    w.refresh = refresh;
    w.last    = last;
    return w;
  endfunction

  // full redraw: upper rows from the store, bottom row blank, store moves up a line
  function automatic void scroll_model(input bit emit);
    int k;
    logic [7:0] g;
    k = 0;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        g = (r == ROWS - 1) ? stc_pkg::SPACE_CODE : shadow_lines[r * COLS + c];
        if (emit)
          pending_writes.push_back(make_write(2'(r), 4'(c), g, k == ROWS * COLS - 1,
                                              k == ROWS * COLS - 1));
        if (r > 0)
          shadow_lines[(r - 1) * COLS + c] = g;
        k++;
      end
    end
    shadow_cursor = 0;
    scrolls_seen++;
  endfunction

  // one character: newline scrolls, a full line scrolls, else one cell on the bottom row
  function automatic void console_model(input logic [7:0] code, input bit emit);
    int col;
    if (code == stc_pkg::NEWLINE_CODE) begin
      scroll_model(emit);
    end else begin
      col = shadow_cursor;
      if (col >= COLS)
        col = COLS - 1;
      shadow_lines[(ROWS - 2) * COLS + col] = code;
      col++;
      if (col >= COLS) begin
        scroll_model(emit);
      end else begin
        if (emit)
          pending_writes.push_back(make_write(2'(ROWS - 1), 4'(col - 1), code, 1'b1, 1'b1));
        shadow_cursor = col;
      end
    end
  endfunction

  function automatic stim_row_t directed_row(input int idx);
    stim_row_t r;
    case (idx)
      0:       r = {8'h00, 1'b1, 4'd0};   // zero byte right after reset
      1:       r = {8'hFF, 1'b1, 4'd1};
      2:       r = {8'h41, 1'b1, 4'd2};
      3:       r = {stc_pkg::NEWLINE_CODE, 1'b0, 4'd0};
      // a whole line, the last character fills it
      4:       r = {8'h09, 1'b1, 4'd0};   // codes next to newline are plain
      5:       r = {8'h0B, 1'b1, 4'd1};
      6:       r = {8'h7F, 1'b1, 4'd2};
      7:       r = {8'h80, 1'b1, 4'd3};
      8:       r = {8'h20, 1'b1, 4'd4};
      9:       r = {8'h55, 1'b1, 4'd5};
      10:      r = {8'hAA, 1'b1, 4'd6};
      11:      r = {8'h01, 1'b1, 4'd7};
      12:      r = {8'hFE, 1'b1, 4'd8};
      13:      r = {8'h31, 1'b1, 4'd9};
      14:      r = {8'h32, 1'b1, 4'd10};
      15:      r = {8'h33, 1'b1, 4'd11};
      16:      r = {8'h34, 1'b1, 4'd12};
      17:      r = {8'h35, 1'b1, 4'd13};
      18:      r = {8'h36, 1'b1, 4'd14};
      19:      r = {8'h5A, 1'b0, 4'd0};
      // newline on an empty line, twice
      20:      r = {stc_pkg::NEWLINE_CODE, 1'b0, 4'd0};
      21:      r = {stc_pkg::NEWLINE_CODE, 1'b0, 4'd0};
      22:      r = {8'h21, 1'b1, 4'd0};
      default: r = {stc_pkg::NEWLINE_CODE, 1'b0, 4'd0};
    endcase
    return r;
  endfunction

  // offer one word and record what it must produce once taken
  task automatic send_char(input logic [7:0] code, input logic typed, input logic [3:0] col);
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= code;
    @(posedge clk);
    while (!in_ch.ready) begin
      stall_cycles++;
      @(posedge clk);
    end
    if (typed) begin
      console_model(code, 1'b0);
      pending_writes.push_back(make_write(2'(ROWS - 1), col, code, 1'b1, 1'b1));
    end else begin
      console_model(code, 1'b1);
    end
    chars_sent++;
  endtask

  // bursts of back-to-back words, random gaps in between
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      in_ch.valid     <= 1'b0;
      in_ch.char_code <= 8'($urandom);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
    end
  endtask

  task automatic flag_field(input string field, input logic [7:0] want, input logic [7:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $error("%s: expected %0h, got %0h", field, want, got);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timed out after %0d cycles, %0d writes still pending",
                 cycles, pending_writes.size());
        $display("[scrolling_text_console] ERROR");
        $finish;
      end
    end
  end

  // receiver: rotating stall patterns, one long hold-off on request
  initial begin : receiver
    int  rx_cycle;
    int  hold_left;
    bit  hold_taken;
    rx_cycle   = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case ((rx_cycle / 150) % 4)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= (rx_cycle % 5 == 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // compare each taken cell write with the oldest pending one
  always @(posedge clk) begin : result_check
    cell_write_t got;
    cell_write_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = make_write(out_ch.screen_row, out_ch.screen_column, out_ch.glyph,
                       out_ch.refresh_now, out_ch.last);
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $error("unexpected cell write: row %0h column %0h glyph %0h",
                 got.row, got.col, got.glyph);
      end else begin
        want = pending_writes.pop_front();
        if (got.row !== want.row)         flag_field("screen_row", want.row, got.row);
        if (got.col !== want.col)         flag_field("screen_column", want.col, got.col);
        if (got.glyph !== want.glyph)     flag_field("glyph", want.glyph, got.glyph);
        if (got.refresh !== want.refresh) flag_field("refresh_now", want.refresh, got.refresh);
        if (got.last !== want.last)       flag_field("last", want.last, got.last);
        writes_checked++;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    stim_row_t  row_i;
    logic [7:0] code;
    int         pick;
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= 8'h00;
    rst_n           <= 1'b0;
    for (int i = 0; i < STORE_CELLS; i++)
      shadow_lines[i] = stc_pkg::SPACE_CODE;
    shadow_cursor = 0;
    burst_left    = $urandom_range(1, 8);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      row_i = directed_row(i);
      send_char(row_i.code, row_i.typed, row_i.col);
      pace_sender();
    end

    // random text: mostly printable, some raw bytes, some newlines
    for (int i = 0; i < RANDOM_CHARS; i++) begin
      if (i == 40)
        hold_req = 1'b1;
      if (i == 120) begin
        // let the block drain completely before going on
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_writes.size() == 0);
        @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 7)
        code = stc_pkg::NEWLINE_CODE;
      else if (pick < 32)
        code = 8'($urandom_range(0, 255));
      else
        code = 8'($urandom_range(8'h20, 8'h7E));
      send_char(code, 1'b0, 4'd0);
      pace_sender();
    end

    in_ch.valid <= 1'b0;
    wait (pending_writes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Typed %0d characters causing %0d scrolls; %0d cell writes checked.",
             chars_sent, scrolls_seen, writes_checked);
    $display("Input was held back for %0d cycles under output back-pressure.", stall_cycles);
    if (mismatches == 0)
      $display("[scrolling_text_console] OK");
    else
      $display("[scrolling_text_console] ERROR");
    $finish;
  end

endmodule
